FILE: src/uudb_pkg.sv
// Shared types and constants for the uudecode body decoder with checksum.
package uudb_pkg;

    localparam int LINE_BUFFER = 80;
    // Largest count whose groups still fit in the line buffer.
    localparam int GROUPS_MAX  = (LINE_BUFFER - 1) / 4;
    localparam int COUNT_FIT   = 3 * GROUPS_MAX;
    localparam int COUNT_MAX   = (COUNT_FIT < 57) ? COUNT_FIT : 57;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;

    localparam logic [7:0] CHAR_NL = 8'd10;

    typedef enum logic [1:0] {
        CMD_BODY  = 2'd0,
        CMD_EOI   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_DONE  = 2'd1,
        ST_LONG  = 2'd2,
        ST_SHORT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        JOB_STATUS = 2'd0,
        JOB_GROUP  = 2'd1,
        JOB_CLEAR  = 2'd2
    } job_kind_t;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        job_kind_t   kind;
        logic [23:0] value;
        logic [1:0]  take;
        logic        last;
        status_t     status;
    } job_t;

endpackage

FILE: src/uudecode_body_with_sum.sv
// Top level of the uudecode body decoder with BSD sum -r checksum.
// Throughput: one character per cycle while the job queue has room; a newline that flushes
// holds input until its padded groups are queued.
// Results: the back end emits one word per cycle while the output is ready, one per byte of a
// group; the 4-entry job queue absorbs these bursts. Sustained rate is set by that byte emitter.
// Reset: rst_n asynchronous active low clears line state, status, checksum and byte count.
module uudecode_body_with_sum
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_byte[7:0], byte_valid[8], running_sum[24:9],
                                   // byte_count[56:25], status[58:57], zero[63:59]
    output logic        m_tlast    // last
);

    uudb_pkg::job_t f_job;
    uudb_pkg::job_t q_job;
    logic           push;
    logic           q_full;
    logic           q_empty;
    logic           pop;

    uudb_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ch       (s_tdata),
        .cmd      (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .job      (f_job)
    );

    uudb_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (f_job),
        .full   (q_full),
        .pop    (pop),
        .empty  (q_empty),
        .rd_job (q_job)
    );

    uudb_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (q_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: src/uudb_front.sv
// Front end: accepts words, tracks line and group state, issues jobs.
module uudb_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    ch,
    input  logic [1:0]    cmd,
    input  logic          q_full,
    output logic          push,
    output uudb_pkg::job_t job
);

    logic                      line_start_reg, line_start_next;
    logic [5:0]                left_reg, left_next;
    logic [17:0]               sb_reg, sb_next;
    logic [1:0]                gp_reg, gp_next;
    logic                      fin_reg, fin_next;
    uudb_pkg::status_t         err_reg, err_next;
    logic                      flush_reg, flush_next;

    logic                      accept;
    logic                      active;
    logic [5:0]                d;
    logic [1:0]                take;
    logic [23:0]               pad;

    assign s_tready = !flush_reg && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign active   = !fin_reg && (err_reg == uudb_pkg::ST_RUN);
    assign d        = ch[5:0] - 6'd32;
    assign take     = (left_reg < 6'd3) ? left_reg[1:0] : 2'd3;

    // Pad the partial group with zero sextets up to four.
    always_comb
    begin
        case (gp_reg)
            2'd1:    pad = {sb_reg[5:0], 18'd0};
            2'd2:    pad = {sb_reg[11:0], 12'd0};
            2'd3:    pad = {sb_reg, 6'd0};
            default: pad = 24'd0;
        endcase
    end

    always_comb
    begin
        line_start_next = line_start_reg;
        left_next       = left_reg;
        sb_next         = sb_reg;
        gp_next         = gp_reg;
        fin_next        = fin_reg;
        err_next        = err_reg;
        flush_next      = flush_reg;
        push            = 1'b0;
        job.kind        = uudb_pkg::JOB_STATUS;
        job.value       = 24'd0;
        job.take        = 2'd0;
        job.last        = 1'b1;

        if (flush_reg)
        begin
            if (!q_full)
            begin
                push      = 1'b1;
                job.kind  = uudb_pkg::JOB_GROUP;
                job.value = pad;
                job.take  = take;
                job.last  = (left_reg == {4'd0, take});
                left_next = left_reg - {4'd0, take};
                sb_next   = 18'd0;
                gp_next   = 2'd0;
                if (left_reg == {4'd0, take})
                begin
                    flush_next      = 1'b0;
                    line_start_next = 1'b1;
                end
            end
        end
        else if (accept)
        begin
            push = 1'b1;
            unique case (uudb_pkg::cmd_t'(cmd))
                uudb_pkg::CMD_BODY:
                begin
                    if (active)
                    begin
                        if (line_start_reg)
                        begin
                            if (ch == uudb_pkg::CHAR_NL)
                            begin
                                // empty line
                            end
                            else if (d == 6'd0)
                                fin_next = 1'b1;
                            else if ({2'd0, d} > 8'(uudb_pkg::COUNT_MAX))
                                err_next = uudb_pkg::ST_LONG;
                            else
                            begin
                                left_next       = d;
                                line_start_next = 1'b0;
                                sb_next         = 18'd0;
                                gp_next         = 2'd0;
                            end
                        end
                        else if (ch == uudb_pkg::CHAR_NL)
                        begin
                            if (left_reg != 6'd0)
                            begin
                                push       = 1'b0;
                                flush_next = 1'b1;
                            end
                            else
                            begin
                                line_start_next = 1'b1;
                                sb_next         = 18'd0;
                                gp_next         = 2'd0;
                            end
                        end
                        else if (left_reg == 6'd0)
                        begin
                            // trailing characters ignored
                        end
                        else if (gp_reg == 2'd3)
                        begin
                            job.kind  = uudb_pkg::JOB_GROUP;
                            job.value = {sb_reg, d};
                            job.take  = take;
                            left_next = left_reg - {4'd0, take};
                            sb_next   = 18'd0;
                            gp_next   = 2'd0;
                        end
                        else
                        begin
                            sb_next = {sb_reg[11:0], d};
                            gp_next = gp_reg + 2'd1;
                        end
                    end
                end
                uudb_pkg::CMD_EOI:
                begin
                    if (active)
                        err_next = uudb_pkg::ST_SHORT;
                end
                uudb_pkg::CMD_CLEAR:
                begin
                    job.kind        = uudb_pkg::JOB_CLEAR;
                    line_start_next = 1'b1;
                    left_next       = 6'd0;
                    sb_next         = 18'd0;
                    gp_next         = 2'd0;
                    fin_next        = 1'b0;
                    err_next        = uudb_pkg::ST_RUN;
                end
                default:
                begin
                end
            endcase
        end

        if (err_next != uudb_pkg::ST_RUN)
            job.status = err_next;
        else if (fin_next)
            job.status = uudb_pkg::ST_DONE;
        else
            job.status = uudb_pkg::ST_RUN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
            left_reg       <= 6'd0;
            sb_reg         <= 18'd0;
            gp_reg         <= 2'd0;
            fin_reg        <= 1'b0;
            err_reg        <= uudb_pkg::ST_RUN;
            flush_reg      <= 1'b0;
        end
        else
        begin
            line_start_reg <= line_start_next;
            left_reg       <= left_next;
            sb_reg         <= sb_next;
            gp_reg         <= gp_next;
            fin_reg        <= fin_next;
            err_reg        <= err_next;
            flush_reg      <= flush_next;
        end
    end

endmodule

FILE: src/uudb_fifo.sv
// Short job queue between the front end and the back end.
module uudb_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  uudb_pkg::job_t wr_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output uudb_pkg::job_t rd_job
);

    uudb_pkg::job_t                 mem [uudb_pkg::FIFO_DEPTH];
    logic [uudb_pkg::FIFO_AW-1:0]   wp_reg, rp_reg;
    logic [uudb_pkg::FIFO_AW:0]     cnt_reg;
    logic                           do_push, do_pop;

    assign full    = (cnt_reg == (uudb_pkg::FIFO_AW+1)'(uudb_pkg::FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= wp_reg + uudb_pkg::FIFO_AW'(1);
            if (do_pop)
                rp_reg <= rp_reg + uudb_pkg::FIFO_AW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + (uudb_pkg::FIFO_AW+1)'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - (uudb_pkg::FIFO_AW+1)'(1);
        end
    end

endmodule

FILE: src/uudb_back.sv
// Back end: emits the bytes of each group job and one word for each other job, keeps checksum and byte count.
module uudb_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  uudb_pkg::job_t q_job,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,
    output logic           m_tlast
);

    uudb_pkg::job_t    job_reg;
    logic              busy_reg;
    logic [1:0]        idx_reg;
    logic [15:0]       sum_reg, sum_next;
    logic [31:0]       cnt_reg, cnt_next;

    logic              mv_reg;
    logic [7:0]        ob_reg, ob_next;
    logic              bv_reg, bv_next;
    logic              ol_reg, ol_next;
    logic [15:0]       os_reg;
    logic [31:0]       oc_reg;
    logic [1:0]        ost_reg;

    logic              slot_free;
    logic              fire;
    logic              final_res;
    logic              done;
    logic [7:0]        sel_byte;

    assign slot_free = !mv_reg || m_tready;
    assign fire      = busy_reg && slot_free;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = job_reg.value[23:16];
            2'd1:    sel_byte = job_reg.value[15:8];
            default: sel_byte = job_reg.value[7:0];
        endcase
    end

    always_comb
    begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        ob_next   = 8'd0;
        bv_next   = 1'b0;
        final_res = 1'b1;
        unique case (job_reg.kind)
            uudb_pkg::JOB_GROUP:
            begin
                // sum -r: rotate right one, add the byte
                sum_next  = {sum_reg[0], sum_reg[15:1]} + {8'd0, sel_byte};
                cnt_next  = cnt_reg + 32'd1;
                ob_next   = sel_byte;
                bv_next   = 1'b1;
                final_res = ((idx_reg + 2'd1) == job_reg.take);
            end
            uudb_pkg::JOB_CLEAR:
            begin
                sum_next = 16'd0;
                cnt_next = 32'd0;
            end
            default:
            begin
            end
        endcase
        ol_next = job_reg.last && final_res;
    end

    assign done = fire && final_res;
    assign pop  = !q_empty && (!busy_reg || done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
            sum_reg  <= 16'd0;
            cnt_reg  <= 32'd0;
            mv_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end
            else if (done)
                busy_reg <= 1'b0;
            else if (fire)
                idx_reg <= idx_reg + 2'd1;

            if (fire)
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
                mv_reg  <= 1'b1;
            end
            else if (m_tready)
                mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_job;
        if (fire)
        begin
            ob_reg  <= ob_next;
            bv_reg  <= bv_next;
            ol_reg  <= ol_next;
            os_reg  <= sum_next;
            oc_reg  <= cnt_next;
            ost_reg <= job_reg.status;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tlast  = ol_reg;
    assign m_tdata  = {5'd0, ost_reg, oc_reg, os_reg, bv_reg, ob_reg};

endmodule
